// ===== hdl/khpt_pkg.sv =====
// Shared types and constants for the key press/hold tracker.
// No dependencies; imported by khpt_slot_alu and the top level.
package khpt_pkg;

    localparam int SLOTS  = 16;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int KEY_W  = 9;
    localparam int TIME_W = 16;
    localparam int CNT_W  = 5;
    localparam int ACT_W  = 2;

    localparam logic [IDX_W-1:0]  LAST_IDX      = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX       = '1;
    localparam logic [TIME_W-1:0] THRESH_RESET  = TIME_W'(500);

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_DOWN  = 2'd1,
        ACT_UP    = 2'd2,
        ACT_QUERY = 2'd3
    } action_t;

    localparam logic [1:0] PH_FREE   = 2'd0;
    localparam logic [1:0] PH_QUEUED = 2'd1;
    localparam logic [1:0] PH_HELD   = 2'd2;

    typedef struct packed {
        logic              pressed;
        logic [1:0]        phase;
        logic [TIME_W-1:0] timer;
        logic [KEY_W-1:0]  code;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef struct packed {
        logic active_hit;
        logic reuse_hit;
        logic free_hit;
        logic promote;
        logic pr;
        logic qu;
        logic he;
    } slot_flags_t;

endpackage

// ===== hdl/khpt_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module khpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/khpt_slot_alu.sv =====
// Read-modify-write logic for one slot entry during a table scan.
// Depends on khpt_pkg.
module khpt_slot_alu import khpt_pkg::*; (
    input  action_t           action,
    input  logic [KEY_W-1:0]  key,
    input  logic [TIME_W-1:0] elapsed,
    input  logic [TIME_W-1:0] threshold,
    input  slot_t             rd_slot,
    output slot_t             wr_slot,
    output logic              wr_en,
    output slot_flags_t       flags
);

    logic            active;
    logic            match;
    logic [TIME_W:0] sum;
    logic [TIME_W-1:0] sat;

    always_comb begin
        active  = (rd_slot.phase == PH_QUEUED) || (rd_slot.phase == PH_HELD);
        match   = (rd_slot.code == key);
        sum     = {1'b0, rd_slot.timer} + {1'b0, elapsed};
        sat     = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        wr_slot = rd_slot;
        wr_en   = 1'b0;
        flags   = '0;

        unique case (action)
            ACT_TICK: begin
                wr_en           = 1'b1;
                wr_slot.pressed = 1'b0;
                if (rd_slot.phase == PH_QUEUED) begin
                    wr_slot.timer = sat;
                    if (sat >= threshold) begin
                        wr_slot.phase = PH_HELD;
                        flags.promote = 1'b1;
                    end
                end
            end
            ACT_UP: begin
                wr_en = 1'b1;
                if (active && match) begin
                    wr_slot.phase = PH_FREE;
                end
            end
            ACT_DOWN, ACT_QUERY: begin
                wr_en = 1'b0;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase

        flags.active_hit = active && match;
        flags.reuse_hit  = !active && rd_slot.pressed && match;
        flags.free_hit   = !active && !rd_slot.pressed;
        if (action != ACT_TICK) begin
            flags.pr = match && wr_slot.pressed;
            flags.qu = match && (wr_slot.phase == PH_QUEUED);
            flags.he = match && (wr_slot.phase == PH_HELD);
        end
    end

endmodule

// ===== hdl/key_press_hold_tracker.sv =====
// Key press/hold tracker top level: sequencer, slot table RAM, result register.
// Depends on khpt_pkg, khpt_ram, khpt_slot_alu.
//
//  channel | ports                        | beat contents
//  --------+------------------------------+------------------------------------------
//  s_      | s_tvalid s_tready s_tdata/user| action, key_code, elapsed_ms
//  m_      | m_tvalid m_tready m_tdata    | pressed, queued, held, dropped, promoted
//  cfg_    | cfg_we cfg_wdata             | hold_threshold_ms
//
// Every item scans all SLOTS table entries through the RAM read port;
// a key-down then passes through S_WRITE for the slot write before the result.
// After reset a clearing pass writes zero to all SLOTS entries before the first beat is taken.
// One item at a time; a stalled result holds the sequencer in its final state.
module key_press_hold_tracker import khpt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [8:0] key_code, [24:9] elapsed_ms, rest zero
    input  logic [ACT_W-1:0]  s_tuser,   // [1:0] action
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [0] pressed, [1] queued, [2] held,
                                         // [3] dropped_full, [8:4] promoted_count
    input  logic              cfg_we,
    input  logic [TIME_W-1:0] cfg_wdata
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } state_t;

    state_t            state_reg,       state_next;
    logic [IDX_W-1:0]  rd_idx_reg,      rd_idx_next;
    logic              rd_done_reg,     rd_done_next;
    logic              rd_pend_reg,     rd_pend_next;
    logic [IDX_W-1:0]  pr_idx_reg,      pr_idx_next;
    action_t           act_reg,         act_next;
    logic [KEY_W-1:0]  key_reg,         key_next;
    logic [TIME_W-1:0] elapsed_reg,     elapsed_next;
    logic [TIME_W-1:0] thr_reg,         thr_next;
    logic              pr_reg,          pr_next;
    logic              qu_reg,          qu_next;
    logic              he_reg,          he_next;
    logic              dropped_reg,     dropped_next;
    logic [CNT_W-1:0]  promo_reg,       promo_next;
    logic              active_hit_reg,  active_hit_next;
    logic              reuse_found_reg, reuse_found_next;
    logic [IDX_W-1:0]  reuse_idx_reg,   reuse_idx_next;
    logic              free_found_reg,  free_found_next;
    logic [IDX_W-1:0]  free_idx_reg,    free_idx_next;
    logic              m_tvalid_reg,    m_tvalid_next;
    logic [15:0]       m_tdata_reg,     m_tdata_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    slot_t             ram_wdata;
    logic [SLOT_W-1:0] ram_rdata;
    slot_t             alu_wr;
    logic              alu_we;
    slot_flags_t       alu_flags;
    slot_t             new_slot;

    khpt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    khpt_slot_alu u_alu (
        .action    (act_reg),
        .key       (key_reg),
        .elapsed   (elapsed_reg),
        .threshold (thr_reg),
        .rd_slot   (slot_t'(ram_rdata)),
        .wr_slot   (alu_wr),
        .wr_en     (alu_we),
        .flags     (alu_flags)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        new_slot         = '0;
        new_slot.pressed = 1'b1;
        new_slot.phase   = PH_QUEUED;
        new_slot.code    = key_reg;
    end

    // table write port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pr_idx_reg;
        ram_wdata = alu_wr;
        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = rd_idx_reg;
                ram_wdata = '0;
            end
            S_SCAN: begin
                ram_we = rd_pend_reg && alu_we;
            end
            S_WRITE: begin
                ram_we    = !active_hit_reg && (reuse_found_reg || free_found_reg);
                ram_waddr = reuse_found_reg ? reuse_idx_reg : free_idx_reg;
                ram_wdata = new_slot;
            end
            S_IDLE, S_DONE: begin
                ram_we = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next       = state_reg;
        rd_idx_next      = rd_idx_reg;
        rd_done_next     = rd_done_reg;
        rd_pend_next     = (state_reg == S_SCAN) && !rd_done_reg;
        pr_idx_next      = rd_idx_reg;
        act_next         = act_reg;
        key_next         = key_reg;
        elapsed_next     = elapsed_reg;
        thr_next         = cfg_we ? cfg_wdata : thr_reg;
        pr_next          = pr_reg;
        qu_next          = qu_reg;
        he_next          = he_reg;
        dropped_next     = dropped_reg;
        promo_next       = promo_reg;
        active_hit_next  = active_hit_reg;
        reuse_found_next = reuse_found_reg;
        reuse_idx_next   = reuse_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;

        unique case (state_reg)
            S_CLEAR: begin
                rd_idx_next = rd_idx_reg + 1'b1;
                if (rd_idx_reg == LAST_IDX) begin
                    rd_idx_next = '0;
                    state_next  = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next       = S_SCAN;
                    rd_idx_next      = '0;
                    rd_done_next     = 1'b0;
                    act_next         = action_t'(s_tuser);
                    key_next         = s_tdata[KEY_W-1:0];
                    elapsed_next     = s_tdata[KEY_W +: TIME_W];
                    pr_next          = 1'b0;
                    qu_next          = 1'b0;
                    he_next          = 1'b0;
                    dropped_next     = 1'b0;
                    promo_next       = '0;
                    active_hit_next  = 1'b0;
                    reuse_found_next = 1'b0;
                    free_found_next  = 1'b0;
                end
            end
            S_SCAN: begin
                if (!rd_done_reg) begin
                    if (rd_idx_reg == LAST_IDX) begin
                        rd_done_next = 1'b1;
                    end else begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
                if (rd_pend_reg) begin
                    pr_next         = pr_reg || alu_flags.pr;
                    qu_next         = qu_reg || alu_flags.qu;
                    he_next         = he_reg || alu_flags.he;
                    active_hit_next = active_hit_reg || alu_flags.active_hit;
                    if (alu_flags.promote && (promo_reg != CNT_MAX)) begin
                        promo_next = promo_reg + 1'b1;
                    end
                    if (alu_flags.reuse_hit && !reuse_found_reg) begin
                        reuse_found_next = 1'b1;
                        reuse_idx_next   = pr_idx_reg;
                    end
                    if (alu_flags.free_hit && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = pr_idx_reg;
                    end
                    if (pr_idx_reg == LAST_IDX) begin
                        state_next = (act_reg == ACT_DOWN) ? S_WRITE : S_DONE;
                    end
                end
            end
            S_WRITE: begin
                priority if (active_hit_reg) begin
                    dropped_next = 1'b0;
                end else if (reuse_found_reg || free_found_reg) begin
                    pr_next = 1'b1;
                    qu_next = 1'b1;
                    he_next = 1'b0;
                end else begin
                    dropped_next = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, promo_reg, dropped_reg, he_reg, qu_reg, pr_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            rd_idx_reg      <= '0;
            rd_done_reg     <= 1'b0;
            rd_pend_reg     <= 1'b0;
            thr_reg         <= THRESH_RESET;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            rd_idx_reg      <= rd_idx_next;
            rd_done_reg     <= rd_done_next;
            rd_pend_reg     <= rd_pend_next;
            thr_reg         <= thr_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pr_idx_reg      <= pr_idx_next;
        act_reg         <= act_next;
        key_reg         <= key_next;
        elapsed_reg     <= elapsed_next;
        pr_reg          <= pr_next;
        qu_reg          <= qu_next;
        he_reg          <= he_next;
        dropped_reg     <= dropped_next;
        promo_reg       <= promo_next;
        active_hit_reg  <= active_hit_next;
        reuse_found_reg <= reuse_found_next;
        reuse_idx_reg   <= reuse_idx_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        m_tdata_reg     <= m_tdata_next;
    end

    // one item in flight: an accepted beat blocks the next cycle's accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on back-to-back cycles");

    // a key is never both queued and held
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[1] && m_tdata[2]))
        else $error("key reported queued and held");

    // a dropped key-down reports no status and no promotions
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3]) |-> (m_tdata[2:0] == 3'b000 && m_tdata[8:4] == 5'd0))
        else $error("dropped key-down with status bits set");

    // promotions come only from a tick, which reports no key status
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8:4] != 5'd0) |-> (m_tdata[3:0] == 4'b0000))
        else $error("promotion count with key status");

endmodule
